FILE: rtl/sorted_priority_queue_top_macros.svh
// Assertion macros for the verification file of the priority queue.
// All of them sample on clk and are disabled while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    // Queue capacity and derived widths
    localparam int DEPTH   = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W   = 34;
    localparam int TAG_W   = 16;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    // Item opcodes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the held item to the list and load the result
    } dp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue, DEPTH entries held in a row of compare-and-shift cells.
// The item register captures the input; the cell row and result register are then updated from it.
// The input stalls while an item is held; a new item is taken only once the held one is applied.
// A stalled result holds the update cycle until the result register drains.
// Reset (rst_n low, asynchronous) empties the queue at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              cmd,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [TAG_W-1:0]  tag,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic [KEY_W-1:0]       out_key,
    output logic [TAG_W-1:0]       out_tag,
    output logic [OCC_W-1:0]       occupancy
);

    dp_cmd_t dp_cmd;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    spq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .cmd       (cmd),
        .key       (key),
        .tag       (tag),
        .status    (status),
        .out_key   (out_key),
        .out_tag   (out_tag),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

FILE: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output dp_cmd_t      dp_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Result register can take a new value when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        dp_cmd.load    = 1'b0;
        dp_cmd.exec    = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    dp_cmd.exec    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           dp_cmd,
    input  wire logic              cmd,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [TAG_W-1:0]  tag,
    output logic [STAT_W-1:0]      status,
    output logic [KEY_W-1:0]       out_key,
    output logic [TAG_W-1:0]       out_tag,
    output logic [OCC_W-1:0]       occupancy
);

    // Held item
    logic               item_cmd_reg;
    logic [KEY_W-1:0]   item_key_reg;
    logic [TAG_W-1:0]   item_tag_reg;

    // Sorted cell row, slot 0 holds the smallest key
    logic [KEY_W-1:0]   key_reg  [DEPTH];
    logic [TAG_W-1:0]   tag_reg  [DEPTH];
    logic [KEY_W-1:0]   key_next [DEPTH];
    logic [TAG_W-1:0]   tag_next [DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;

    // Result register
    status_t            status_reg, status_next;
    logic [KEY_W-1:0]   out_key_reg, out_key_next;
    logic [TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic [OCC_W-1:0]   occ_reg;

    logic [DEPTH-1:0]   valid;
    logic [DEPTH-1:0]   gt;
    logic               full;
    logic               empty;
    logic               do_insert;
    logic               do_remove;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_insert = dp_cmd.exec && (item_cmd_reg == CMD_INSERT) && !full;
    assign do_remove = dp_cmd.exec && (item_cmd_reg == CMD_REMOVE) && !empty;

    // Per-cell logic: occupancy, compare and shift selection
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic at_end;

        assign valid[g] = (COUNT_W'(g) < count_reg);
        assign gt[g]    = valid[g] && (key_reg[g] > item_key_reg);
        assign at_end   = (count_reg == COUNT_W'(g));

        always_comb
        begin
            key_next[g] = key_reg[g];
            tag_next[g] = tag_reg[g];
            if (do_insert)
            begin
                if (g > 0 && gt[(g > 0) ? g - 1 : 0])
                begin
                    // larger key moves one slot toward the tail
                    key_next[g] = key_reg[(g > 0) ? g - 1 : 0];
                    tag_next[g] = tag_reg[(g > 0) ? g - 1 : 0];
                end
                else if (gt[g] || at_end)
                begin
                    // first slot past all keys not above the new one
                    key_next[g] = item_key_reg;
                    tag_next[g] = item_tag_reg;
                end
            end
            else if (do_remove && g < DEPTH - 1)
            begin
                key_next[g] = key_reg[(g < DEPTH - 1) ? g + 1 : g];
                tag_next[g] = tag_reg[(g < DEPTH - 1) ? g + 1 : g];
            end
        end

        always_ff @(posedge clk)
        begin
            key_reg[g] <= key_next[g];
            tag_reg[g] <= tag_next[g];
        end
    end

    // Count and result values
    always_comb
    begin
        count_next   = count_reg;
        status_next  = status_reg;
        out_key_next = '0;
        out_tag_next = '0;
        if (item_cmd_reg == CMD_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                count_next  = count_reg + 1'b1;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next  = ST_REMOVED;
                out_key_next = key_reg[0];
                out_tag_next = tag_reg[0];
                count_next   = count_reg - 1'b1;
            end
        end
    end

    // Entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dp_cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            item_cmd_reg <= cmd;
            item_key_reg <= key;
            item_tag_reg <= tag;
        end
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            status_reg  <= status_next;
            out_key_reg <= out_key_next;
            out_tag_reg <= out_tag_next;
            occ_reg     <= OCC_W'(count_next);
        end
    end

    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign occupancy = occ_reg;

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"

module spq_checker
    import spq_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [STAT_W-1:0] status,
    input wire logic [KEY_W-1:0]  out_key,
    input wire logic [TAG_W-1:0]  out_tag,
    input wire logic [OCC_W-1:0]  occupancy
);

    logic in_xfer;
    logic non_remove;

    assign in_xfer    = in_valid && !in_stall;
    assign non_remove = (status == ST_INSERTED) || (status == ST_FULL) ||
                        (status == ST_EMPTY);

    // One item at a time: the input stalls right after a transfer
    `SPQ_ASSERT_NEXT(a_one_in_flight, in_xfer, in_stall, "input taken while item in flight")

    // Only a real removal carries a key and tag
    `SPQ_ASSERT_NOW(a_zero_payload, out_valid && non_remove, out_key == '0 && out_tag == '0, "payload not zero")

    // A dropped insert reports a full queue
    `SPQ_ASSERT_NOW(a_full_occ, out_valid && status == ST_FULL, occupancy == OCC_W'(DEPTH), "full with wrong occupancy")

    // An empty remove reports no entries
    `SPQ_ASSERT_NOW(a_empty_occ, out_valid && status == ST_EMPTY, occupancy == '0, "empty with entries")

    // A stalled result holds
    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_key) && $stable(status), "stalled result changed")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire
